/* hw/rtl/jscs_pkg.sv */
// Shared types, constants and register indexes for the joystick servo command shaper.
package jscs_pkg;

    // Fixed-point and command widths
    localparam int AXIS_FRAC_BITS = 14;
    localparam int CMD_BITS       = 12;
    localparam int AXIS_W         = 16;
    localparam int BTN_W          = 8;

    // (axis + 2.0) needs two bits above the 16-bit axis
    localparam int SUM_W  = AXIS_W + 2;
    // signed span full_max - full_min
    localparam int SPAN_W = CMD_BITS + 1;
    localparam int PROD_W = SUM_W + SPAN_W;
    // divide by 4.0 in Q(AXIS_FRAC_BITS)
    localparam int SCALE_SHIFT = AXIS_FRAC_BITS + 2;
    // signed width for the slew arithmetic
    localparam int SLEW_W = CMD_BITS + 2;

    localparam logic signed [SUM_W-1:0] AXIS_ONE = SUM_W'(1) <<< AXIS_FRAC_BITS;
    localparam logic [CMD_BITS-1:0] CMD_MASK = {CMD_BITS{1'b1}};
    localparam logic signed [PROD_W-1:0] SAT_HI = PROD_W'({1'b0, CMD_MASK});

    // Configuration register reset values
    localparam logic [CMD_BITS-1:0] FULL_MAX_RST  = CMD_BITS'(2000);
    localparam logic [CMD_BITS-1:0] FULL_MIN_RST  = CMD_BITS'(1000);
    localparam logic                SLOW_EN_RST   = 1'b1;
    localparam logic [CMD_BITS-1:0] SLOW_MAX_RST  = CMD_BITS'(1550);
    localparam logic [CMD_BITS-1:0] SLOW_MIN_RST  = CMD_BITS'(1450);
    localparam logic [CMD_BITS-1:0] MAX_STEP_RST  = CMD_BITS'(4);
    localparam logic [CMD_BITS:0]   NEUTRAL_SUM_RST =
        {1'b0, FULL_MAX_RST} + {1'b0, FULL_MIN_RST};
    localparam logic [CMD_BITS-1:0] NEUTRAL_RST = NEUTRAL_SUM_RST[CMD_BITS:1];

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_MAX = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_MIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SLOW_EN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SLOW_MAX = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SLOW_MIN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_STEP = 3'd5;

    // Button bit positions
    localparam int BTN_DRIVE_ON  = 0;
    localparam int BTN_DRIVE_OFF = 1;
    localparam int BTN_RACE      = 2;
    localparam int BTN_ODOM      = 3;
    localparam int BTN_OUT_OFF   = 4;
    localparam int BTN_OUT_ON    = 5;
    localparam int BTN_MAP_SAVE  = 7;

    typedef enum logic [1:0] {
        CMD_SAMPLE     = 2'd0,
        CMD_TICK       = 2'd1,
        CMD_SET_ENABLE = 2'd2
    } command_t;

    typedef struct packed {
        logic [CMD_BITS-1:0] full_max;
        logic [CMD_BITS-1:0] full_min;
    } range_cfg_t;

endpackage

/* hw/rtl/joystick_servo_command_shaper_top.sv */
// Top level of the joystick servo command shaper.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one transaction per command:
//   a gamepad sample, a tick, or a direct output-enable write. Every input
//   transaction yields exactly one result transaction on the output channel
//   (out_valid / out_stall) with the current drive and steering commands,
//   the publish flag and the button request pulses.
//   Path: two stages, an input register and then a result register, with
//   the compute stage between them.
//   Throughput: one transaction per cycle while the output is not stalled;
//   the single compute stage holds two scaling multipliers in parallel
//   between the input and result registers.
//   Stall: when the result register is full and stalled, the input register
//   holds its transaction and in_stall rises; nothing is dropped.
//   Reset: configuration returns to reset values, commands to neutral (1500),
//   edge history and output enable clear. Users must write configuration
//   (cfg_we / cfg_index / cfg_data) only while idle; it is not enforced.
module joystick_servo_command_shaper_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration
    input  logic                                 cfg_we,
    input  logic [jscs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [jscs_pkg::CMD_BITS-1:0]        cfg_data,
    // input channel
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [1:0]                           command,
    input  logic signed [jscs_pkg::AXIS_W-1:0]   fwd_axis,
    input  logic signed [jscs_pkg::AXIS_W-1:0]   rev_axis,
    input  logic signed [jscs_pkg::AXIS_W-1:0]   steer_axis,
    input  logic [jscs_pkg::BTN_W-1:0]           buttons,
    input  logic                                 enable_value,
    // output channel
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [jscs_pkg::CMD_BITS-1:0]        drive_out,
    output logic [jscs_pkg::CMD_BITS-1:0]        steer_out,
    output logic                                 publish,
    output logic                                 drive_request,
    output logic                                 drive_request_value,
    output logic                                 odom_reset_pulse,
    output logic                                 save_map_pulse,
    output logic                                 race_start_pulse
);
    import jscs_pkg::*;

    // ---------------- configuration registers ----------------
    logic [CMD_BITS-1:0] full_max_reg;
    logic [CMD_BITS-1:0] full_min_reg;
    logic                slow_en_reg;
    logic [CMD_BITS-1:0] slow_max_reg;
    logic [CMD_BITS-1:0] slow_min_reg;
    logic [CMD_BITS-1:0] max_step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_max_reg <= FULL_MAX_RST;
            full_min_reg <= FULL_MIN_RST;
            slow_en_reg  <= SLOW_EN_RST;
            slow_max_reg <= SLOW_MAX_RST;
            slow_min_reg <= SLOW_MIN_RST;
            max_step_reg <= MAX_STEP_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FULL_MAX: full_max_reg <= cfg_data;
                REG_FULL_MIN: full_min_reg <= cfg_data;
                REG_SLOW_EN:  slow_en_reg  <= cfg_data[0];
                REG_SLOW_MAX: slow_max_reg <= cfg_data;
                REG_SLOW_MIN: slow_min_reg <= cfg_data;
                REG_MAX_STEP: max_step_reg <= cfg_data;
                default: ;  // unmapped index: write ignored
            endcase
        end
    end

    // ---------------- input register stage ----------------
    logic                       in_vld_reg;
    logic [1:0]                 cmd_reg;
    logic signed [AXIS_W-1:0]   fwd_reg;
    logic signed [AXIS_W-1:0]   rev_reg;
    logic signed [AXIS_W-1:0]   steer_ax_reg;
    logic [BTN_W-1:0]           btn_reg;
    logic                       en_val_reg;

    logic out_vld_reg;
    logic advance;
    logic in_take;

    // compute stage moves when the result register is empty or being drained
    assign advance  = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall = in_vld_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_vld_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            cmd_reg      <= command;
            fwd_reg      <= fwd_axis;
            rev_reg      <= rev_axis;
            steer_ax_reg <= steer_axis;
            btn_reg      <= buttons;
            en_val_reg   <= enable_value;
        end
    end

    // ---------------- block state ----------------
    logic [CMD_BITS-1:0] drive_value_reg, drive_value_next;
    logic [CMD_BITS-1:0] steer_value_reg, steer_value_next;
    logic [CMD_BITS-1:0] drive_last_reg,  drive_last_next;
    logic [BTN_W-1:0]    btn_last_reg,    btn_last_next;
    logic                seen_reg,        seen_next;
    logic                out_en_reg,      out_en_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drive_value_reg <= NEUTRAL_RST;
            steer_value_reg <= NEUTRAL_RST;
            drive_last_reg  <= NEUTRAL_RST;
            btn_last_reg    <= '0;
            seen_reg        <= 1'b0;
            out_en_reg      <= 1'b0;
        end
        else if (advance)
        begin
            drive_value_reg <= drive_value_next;
            steer_value_reg <= steer_value_next;
            drive_last_reg  <= drive_last_next;
            btn_last_reg    <= btn_last_next;
            seen_reg        <= seen_next;
            out_en_reg      <= out_en_next;
        end
    end

    // ---------------- sample path: axis scaling ----------------
    range_cfg_t              range_cfg;
    logic                    fwd_released;
    logic signed [SUM_W-1:0] fwd_ext, rev_ext, steer_ext;
    logic signed [SUM_W-1:0] drive_x, steer_x;
    logic [CMD_BITS-1:0]     drive_scaled, steer_scaled;

    assign range_cfg.full_max = full_max_reg;
    assign range_cfg.full_min = full_min_reg;

    assign fwd_ext   = SUM_W'(fwd_reg);
    assign rev_ext   = SUM_W'(rev_reg);
    assign steer_ext = SUM_W'(steer_ax_reg);

    // reverse trigger only counts while forward sits exactly at released
    assign fwd_released = (fwd_ext == AXIS_ONE) && (rev_ext != AXIS_ONE);
    // offsets already include the +2.0 bias of the scaler
    assign drive_x = fwd_released ? (rev_ext + AXIS_ONE)
                                  : ((AXIS_ONE + (AXIS_ONE <<< 1)) - fwd_ext);
    assign steer_x = steer_ext + (AXIS_ONE <<< 1);

    jscs_scale u_scale_drive (
        .x         (drive_x),
        .range_cfg (range_cfg),
        .cmd       (drive_scaled)
    );

    jscs_scale u_scale_steer (
        .x         (steer_x),
        .range_cfg (range_cfg),
        .cmd       (steer_scaled)
    );

    // ---------------- tick path: slow clamp and slew limit ----------------
    logic [CMD_BITS:0]          neutral_sum;
    logic [CMD_BITS-1:0]        neutral;
    logic [CMD_BITS-1:0]        clamped;
    logic signed [SLEW_W-1:0]   clamped_s, last_up, last_dn, slewed;
    logic [CMD_BITS-1:0]        slewed_sat;

    assign neutral_sum = {1'b0, full_max_reg} + {1'b0, full_min_reg};
    assign neutral     = neutral_sum[CMD_BITS:1];

    always_comb
    begin
        if (drive_value_reg > slow_max_reg)
        begin
            clamped = slow_max_reg;
        end
        else if (drive_value_reg < slow_min_reg)
        begin
            clamped = slow_min_reg;
        end
        else
        begin
            clamped = drive_value_reg;
        end
    end

    assign clamped_s = $signed({2'b00, clamped});
    assign last_up   = $signed({2'b00, drive_last_reg}) + $signed({2'b00, max_step_reg});
    assign last_dn   = $signed({2'b00, drive_last_reg}) - $signed({2'b00, max_step_reg});

    always_comb
    begin
        if ((clamped > neutral) && (clamped_s > last_up))
        begin
            slewed = last_up;
        end
        else if ((clamped < neutral) && (clamped_s < last_dn))
        begin
            slewed = last_dn;
        end
        else
        begin
            slewed = clamped_s;
        end
    end

    always_comb
    begin
        if (slewed < 0)
        begin
            slewed_sat = '0;
        end
        else if (slewed > $signed({2'b00, CMD_MASK}))
        begin
            slewed_sat = CMD_MASK;
        end
        else
        begin
            slewed_sat = slewed[CMD_BITS-1:0];
        end
    end

    // ---------------- next state and result ----------------
    logic [BTN_W-1:0] rise;
    logic publish_next, dreq_next, dval_next, odom_next, smap_next, race_next;

    // first sample: history is taken from the sample itself, so no edges
    assign rise = seen_reg ? (btn_reg & ~btn_last_reg) : '0;

    always_comb
    begin
        drive_value_next = drive_value_reg;
        steer_value_next = steer_value_reg;
        drive_last_next  = drive_last_reg;
        btn_last_next    = btn_last_reg;
        seen_next        = seen_reg;
        out_en_next      = out_en_reg;
        publish_next     = 1'b0;
        dreq_next        = 1'b0;
        dval_next        = 1'b0;
        odom_next        = 1'b0;
        smap_next        = 1'b0;
        race_next        = 1'b0;

        case (command_t'(cmd_reg))
            CMD_SAMPLE:
            begin
                drive_value_next = drive_scaled;
                steer_value_next = steer_scaled;
                btn_last_next    = btn_reg;
                seen_next        = 1'b1;
                if (rise[BTN_DRIVE_ON])
                begin
                    dreq_next = 1'b1;
                    dval_next = 1'b1;
                end
                else if (rise[BTN_DRIVE_OFF])
                begin
                    dreq_next = 1'b1;
                end
                if (rise[BTN_OUT_ON])
                begin
                    out_en_next = 1'b1;
                end
                else if (rise[BTN_OUT_OFF])
                begin
                    out_en_next = 1'b0;
                end
                odom_next = rise[BTN_ODOM];
                smap_next = rise[BTN_MAP_SAVE];
                race_next = rise[BTN_RACE];
            end
            CMD_TICK:
            begin
                if (slow_en_reg)
                begin
                    drive_value_next = slewed_sat;
                    drive_last_next  = slewed_sat;
                end
                publish_next = out_en_reg;
            end
            CMD_SET_ENABLE:
            begin
                out_en_next = en_val_reg;
            end
            default: ;  // unused code: state kept, plain report
        endcase
    end

    // ---------------- result register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    logic [CMD_BITS-1:0] drive_out_reg, steer_out_reg;
    logic publish_reg, dreq_reg, dval_reg, odom_reg, smap_reg, race_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            drive_out_reg <= drive_value_next;
            steer_out_reg <= steer_value_next;
            publish_reg   <= publish_next;
            dreq_reg      <= dreq_next;
            dval_reg      <= dval_next;
            odom_reg      <= odom_next;
            smap_reg      <= smap_next;
            race_reg      <= race_next;
        end
    end

    assign out_valid           = out_vld_reg;
    assign drive_out           = drive_out_reg;
    assign steer_out           = steer_out_reg;
    assign publish             = publish_reg;
    assign drive_request       = dreq_reg;
    assign drive_request_value = dval_reg;
    assign odom_reset_pulse    = odom_reg;
    assign save_map_pulse      = smap_reg;
    assign race_start_pulse    = race_reg;

endmodule

/* hw/rtl/jscs_scale.sv */
// Linear axis-to-command scaler: floor(x * span / 4.0) + full_min, saturated; x already carries the +2.0 bias.
module jscs_scale (
    input  logic signed [jscs_pkg::SUM_W-1:0]  x,
    input  jscs_pkg::range_cfg_t               range_cfg,
    output logic        [jscs_pkg::CMD_BITS-1:0] cmd
);
    import jscs_pkg::*;

    logic signed [SPAN_W-1:0] span;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] quot;
    logic signed [PROD_W-1:0] sum;

    assign span = $signed({1'b0, range_cfg.full_max}) - $signed({1'b0, range_cfg.full_min});
    assign prod = PROD_W'(x) * PROD_W'(span);
    // arithmetic shift gives the floor for negative products
    assign quot = prod >>> SCALE_SHIFT;
    assign sum  = quot + $signed(PROD_W'({1'b0, range_cfg.full_min}));

    always_comb
    begin
        if (sum < 0)
        begin
            cmd = '0;
        end
        else if (sum > SAT_HI)
        begin
            cmd = CMD_MASK;
        end
        else
        begin
            cmd = sum[CMD_BITS-1:0];
        end
    end

endmodule
